// ----- src/usan_pkg.sv -----
// usan_pkg: types, constants and the sequence judge for the utf-8 sanitizer
// no dependencies; imported by every module under src
`default_nettype none

package usan_pkg;

  localparam int USAN_QUEUE_DEPTH = 4;

  localparam logic [7:0] REPL_BYTE0 = 8'hef;
  localparam logic [7:0] REPL_BYTE1 = 8'hbf;
  localparam logic [7:0] REPL_BYTE2 = 8'hbd;

  typedef enum logic [1:0] {
    VERD_FAIL,
    VERD_OK,
    VERD_WAIT
  } verdict_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_replacement;
    logic       run_last;
    logic       string_done;
  } out_item_t;

  // one emit action: a whole valid sequence or one replaced lead
  typedef struct packed {
    logic            is_fail;
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic            last;
    logic            str_end;
  } token_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7]) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // verdict on the sequence at the head of b, n bytes present (n >= 1)
  function automatic verdict_t judge(input logic [3:0][7:0] b, input logic [2:0] n,
                                     input logic at_end);
    logic [2:0] len;
    logic [2:0] avail;
    logic       bad;
    verdict_t   v;
    len   = lead_len(b[0]);
    avail = (n < len) ? n : len;
    bad   = (len == 3'd0);
    for (int i = 1; i < 4; i++) begin
      if (3'(i) < avail && b[i][7:6] != 2'b10) begin
        bad = 1'b1;
      end
    end
    // overlong two-byte form
    if (len == 3'd2 && b[0][4:1] == 4'd0) begin
      bad = 1'b1;
    end
    // overlong three-byte form or surrogate prefix
    if (len == 3'd3 && n >= 3'd2) begin
      if ((b[0][3:0] == 4'd0 && !b[1][5]) || (b[0][3:0] == 4'hd && b[1][5])) begin
        bad = 1'b1;
      end
    end
    if (len == 3'd4 && n >= 3'd2 && b[0][2:0] == 3'd0 && b[1][5:4] == 2'd0) begin
      bad = 1'b1;
    end
    if (bad) begin
      v = VERD_FAIL;
    end else if (n >= len) begin
      v = VERD_OK;
    end else if (at_end) begin
      v = VERD_FAIL;
    end else begin
      v = VERD_WAIT;
    end
    return v;
  endfunction

  function automatic logic [7:0] repl_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = REPL_BYTE0;
      2'd1:    b = REPL_BYTE1;
      default: b = REPL_BYTE2;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- src/utf8_sanitizer_core.sv -----
// utf8_sanitizer_core: streaming utf-8 check with EF BF BD substitution
// path: a taken input byte passes the front window register, the token queue and the output register
// throughput: one input byte a cycle unless in_stall; output one byte a cycle unless
//   out_stall, so a replaced byte gives three output bytes; the token queue absorbs bursts
// reset: synchronous, active low; clears window count, queue and output valid
// depends on usan_pkg, usan_front, usan_fifo, usan_back
`default_nettype none

module utf8_sanitizer_core #(
  parameter int QueueDepth = usan_pkg::USAN_QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  usan_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output usan_pkg::out_item_t  out_data
);
  import usan_pkg::*;

  logic   tok_push, tok_full, tok_valid, tok_pop;
  token_t tok_wr, tok_rd;

  usan_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .tok_push (tok_push),
    .tok_data (tok_wr),
    .tok_full (tok_full)
  );

  usan_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tok_push),
    .wr_data  (tok_wr),
    .full     (tok_full),
    .rd_en    (tok_pop),
    .rd_valid (tok_valid),
    .rd_data  (tok_rd)
  );

  usan_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok_data  (tok_rd),
    .tok_pop   (tok_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- src/usan_front.sv -----
// usan_front: takes input bytes into a four-byte window and cuts it into emit tokens
// depends on usan_pkg (judge, token_t)
`default_nettype none

module usan_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  usan_pkg::in_item_t   in_data,
  output logic                 tok_push,
  output usan_pkg::token_t     tok_data,
  input  wire                  tok_full
);
  import usan_pkg::*;

  logic [3:0][7:0] buf_r, buf_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic            act_r, act_nxt;
  logic            end_r, end_nxt;

  verdict_t        verd, rem_verd;
  logic [2:0]      used;
  logic [3:0][7:0] rem_buf;
  logic [2:0]      rem_n;
  logic            rem_settle;
  logic            take;
  logic [3:0][7:0] base_buf;
  logic [2:0]      base_n;

  always_comb begin
    verd       = judge(buf_r, cnt_r, end_r);
    used       = (verd == VERD_OK) ? lead_len(buf_r[0]) : 3'd1;
    rem_buf    = buf_r >> {used, 3'b000};
    rem_n      = cnt_r - used;
    rem_verd   = judge(rem_buf, rem_n, end_r);
    // nothing more comes out of this input byte after the current action
    rem_settle = (rem_n == 3'd0) || (rem_verd == VERD_WAIT);

    tok_push = act_r && (verd != VERD_WAIT) && !tok_full;
    tok_data.is_fail = (verd != VERD_OK);
    tok_data.bytes   = buf_r;
    tok_data.len     = used;
    tok_data.last    = rem_settle;
    tok_data.str_end = end_r;

    take     = !act_r || (verd == VERD_WAIT) || (tok_push && rem_settle);
    in_stall = !take;

    if (tok_push) begin
      base_buf = rem_buf;
      base_n   = rem_n;
    end else begin
      base_buf = buf_r;
      base_n   = cnt_r;
    end

    buf_nxt = base_buf;
    cnt_nxt = base_n;
    act_nxt = act_r;
    end_nxt = end_r;
    if (in_valid && take) begin
      buf_nxt[base_n[1:0]] = in_data.in_byte;
      cnt_nxt = base_n + 3'd1;
      act_nxt = 1'b1;
      end_nxt = in_data.end_of_string;
    end else if (tok_push) begin
      act_nxt = !rem_settle;
    end else if (act_r && verd == VERD_WAIT) begin
      act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    end_r <= end_nxt;
    if (!rst_n) begin
      cnt_r <= 3'd0;
      act_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      act_r <= act_nxt;
    end
  end

  a_idle_holds_few: assert property (@(posedge clk) disable iff (!rst_n)
    !act_r |-> cnt_r <= 3'd3) else $error("idle window holds more than three bytes");
  a_active_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> cnt_r != 3'd0) else $error("active window is empty");
  a_no_wait_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    act_r && end_r |-> verd != VERD_WAIT) else $error("wait verdict on last byte of string");

endmodule

`default_nettype wire

// ----- src/usan_fifo.sv -----
// usan_fifo: short token queue between the front and back parts
// depends on usan_pkg (token_t)
`default_nettype none

module usan_fifo #(
  parameter int Depth = usan_pkg::USAN_QUEUE_DEPTH
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               wr_en,
  input  usan_pkg::token_t  wr_data,
  output logic              full,
  input  wire               rd_en,
  output logic              rd_valid,
  output usan_pkg::token_t  rd_data
);
  import usan_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  token_t            mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              do_wr, do_rd;

  always_comb begin
    full     = (count_r == CntW'(Depth));
    rd_valid = (count_r != '0);
    rd_data  = mem_r[rd_ptr_r];
    do_wr    = wr_en && !full;
    do_rd    = rd_en && rd_valid;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CntW'(do_wr) - CntW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth)) else $error("queue count beyond depth");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full)) else $error("token pushed into full queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("empty queue with pointer gap");

endmodule

`default_nettype wire

// ----- src/usan_back.sv -----
// usan_back: plays tokens out one byte a cycle, while out_stall is low, into the output register
// depends on usan_pkg (token_t, out_item_t, repl_byte)
`default_nettype none

module usan_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  tok_valid,
  input  usan_pkg::token_t     tok_data,
  output logic                 tok_pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output usan_pkg::out_item_t  out_data
);
  import usan_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic [2:0] n_bytes;
  logic       last_byte;
  logic       load;

  always_comb begin
    n_bytes   = tok_data.is_fail ? 3'd3 : tok_data.len;
    last_byte = ({1'b0, idx_r} == n_bytes - 3'd1);
    load      = tok_valid && (!out_valid_r || !out_stall);
    tok_pop   = load && last_byte;

    out_data_nxt.out_byte       = tok_data.is_fail ? repl_byte(idx_r) : tok_data.bytes[idx_r];
    out_data_nxt.is_replacement = tok_data.is_fail;
    out_data_nxt.run_last       = tok_data.last && last_byte;
    out_data_nxt.string_done    = tok_data.last && tok_data.str_end && last_byte;

    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last_byte ? 2'd0 : idx_r + 2'd1;
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_idx_in_token: assert property (@(posedge clk) disable iff (!rst_n)
    tok_valid |-> {1'b0, idx_r} < n_bytes) else $error("byte index past token length");
  a_idx_rest: assert property (@(posedge clk) disable iff (!rst_n)
    !tok_valid |-> idx_r == 2'd0) else $error("byte index held without a token");
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    load && out_data_nxt.string_done |-> out_data_nxt.run_last)
    else $error("string end without run end");

endmodule

`default_nettype wire

// ----- dv/utf8_sanitizer_checker.sv -----
// utf8_sanitizer_checker: watches both channels of utf8_sanitizer_core, predicts the
// sanitised byte stream and compares every result field against it
// depends on usan_pkg for the request and result types and the replacement bytes
module utf8_sanitizer_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  usan_pkg::in_item_t  in_data,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  usan_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import usan_pkg::*;

  out_item_t  expected_bytes[$];
  logic [7:0] held [3];
  int         held_cnt = 0;

  function automatic int seq_len(input logic [7:0] b);
    int len;
    if (b < 8'h80) begin
      len = 1;
    end else if ((b & 8'he0) == 8'hc0) begin
      len = 2;
    end else if ((b & 8'hf0) == 8'he0) begin
      len = 3;
    end else if ((b & 8'hf8) == 8'hf0) begin
      len = 4;
    end else begin
      len = 0;
    end
    return len;
  endfunction

  // decision on the sequence at the head of the window, n bytes present
  function automatic verdict_t assess(input logic [7:0] w [4], input int n,
                                      input logic at_end);
    int          len;
    int          avail;
    logic [15:0] code;
    len = seq_len(w[0]);
    if (len == 0) return VERD_FAIL;
    avail = (n < len) ? n : len;
    for (int i = 1; i < avail; i++) begin
      if (w[i][7:6] != 2'b10) return VERD_FAIL;
    end
    if (len == 2 && (w[0] & 8'h1e) == 8'h00) return VERD_FAIL;
    if (len == 3 && n >= 2) begin
      if ((w[0] & 8'h0f) == 8'h00 && (w[1] & 8'h20) == 8'h00) return VERD_FAIL;
      code = {w[0][3:0], w[1][5:0], 6'd0};
      if (n >= 3) code[5:0] = w[2][5:0];
      // surrogates are rejected as soon as the second byte shows them
      if (code >= 16'hd800 && code <= 16'hdfff) return VERD_FAIL;
    end
    if (len == 4 && n >= 2 && (w[0] & 8'h07) == 8'h00 && (w[1] & 8'h30) == 8'h00) begin
      return VERD_FAIL;
    end
    if (n >= len) return VERD_OK;
    return at_end ? VERD_FAIL : VERD_WAIT;
  endfunction

  task automatic sanitize_byte(input in_item_t req);
    logic [7:0] win [4];
    out_item_t  step_out [12];
    out_item_t  r;
    verdict_t   v;
    int         n;
    int         used;
    int         k;
    win = '{default: 8'h00};
    k = 0;
    for (int i = 0; i < held_cnt; i++) win[i] = held[i];
    win[held_cnt] = req.in_byte;
    n = held_cnt + 1;
    while (n > 0) begin
      v = assess(win, n, req.end_of_string);
      if (v == VERD_WAIT) break;
      r = '0;
      if (v == VERD_OK) begin
        used = seq_len(win[0]);
        for (int i = 0; i < used; i++) begin
          r.out_byte = win[i];
          step_out[k] = r;
          k++;
        end
      end else begin
        // only the lead is consumed, the rest is looked at again
        used = 1;
        r.is_replacement = 1'b1;
        r.out_byte = REPL_BYTE0;
        step_out[k] = r;
        r.out_byte = REPL_BYTE1;
        step_out[k + 1] = r;
        r.out_byte = REPL_BYTE2;
        step_out[k + 2] = r;
        k += 3;
      end
      for (int i = 0; i + used < 4; i++) win[i] = win[i + used];
      n -= used;
    end
    for (int i = 0; i < n; i++) held[i] = win[i];
    held_cnt = n;
    for (int i = 0; i < k; i++) begin
      r = step_out[i];
      if (i == k - 1) begin
        r.run_last = 1'b1;
        r.string_done = req.end_of_string;
      end
      expected_bytes.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      held_cnt = 0;
    end else begin
      if (in_valid && !in_stall) begin
        sanitize_byte(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: result expected none got %h", $time, out_data);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h got %02h", $time, want.out_byte,
                     out_data.out_byte);
            mismatches++;
          end
          if (out_data.is_replacement !== want.is_replacement) begin
            $display("%0t: is_replacement expected %b got %b", $time, want.is_replacement,
                     out_data.is_replacement);
            mismatches++;
          end
          if (out_data.run_last !== want.run_last) begin
            $display("%0t: run_last expected %b got %b", $time, want.run_last,
                     out_data.run_last);
            mismatches++;
          end
          if (out_data.string_done !== want.string_done) begin
            $display("%0t: string_done expected %b got %b", $time, want.string_done,
                     out_data.string_done);
            mismatches++;
          end
        end
      end
    end
    owed = expected_bytes.size();
  end

endmodule

// ----- dv/utf8_sanitizer_core_tb.sv -----
// utf8_sanitizer_core_tb: drives strings of directed and random utf-8 bytes into
// utf8_sanitizer_core with random gaps and stalls; checking sits in utf8_sanitizer_checker
// depends on usan_pkg, utf8_sanitizer_core and utf8_sanitizer_checker
module utf8_sanitizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import usan_pkg::*;

  localparam int QuietLimit = 2000;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  int        mismatches;
  int        owed;
  int        quiet = 0;
  bit        idle_off = 1'b0;
  logic [7:0] text[$];

  utf8_sanitizer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  utf8_sanitizer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .owed       (owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_wait();
    return idle_off ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hbf));
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, end_of_string: eos};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) push_byte(text[i], i == text.size() - 1);
    text.delete();
  endtask

  // hold off new requests until every predicted byte has come out
  task automatic wait_for_output();
    in_valid <= 1'b0;
    do @(negedge clk); while (owed != 0);
    @(posedge clk);
  endtask

  // one character: mostly well formed, else noise, truncated, corrupt, overlong, surrogate or stray continuation
  task automatic add_char();
    logic [7:0] s [4];
    int len;
    int kind;
    int keep;
    int pos;
    len = $urandom_range(1, 4);
    s[1] = cont_byte();
    s[2] = cont_byte();
    s[3] = cont_byte();
    case (len)
      1: begin
        s[0] = 8'($urandom_range(0, 8'h7f));
      end
      2: begin
        s[0] = 8'($urandom_range(8'hc2, 8'hdf));
      end
      3: begin
        s[0] = 8'($urandom_range(8'he0, 8'hef));
        if (s[0] == 8'he0) s[1] = 8'($urandom_range(8'ha0, 8'hbf));
        else if (s[0] == 8'hed) s[1] = 8'($urandom_range(8'h80, 8'h9f));
      end
      default: begin
        s[0] = 8'($urandom_range(8'hf0, 8'hf7));
        if (s[0] == 8'hf0) s[1] = 8'($urandom_range(8'h90, 8'hbf));
      end
    endcase
    kind = $urandom_range(0, 19);
    keep = len;
    if (kind == 15) begin
      keep = 1;
      s[0] = 8'($urandom);
    end else if (kind == 16 && len > 1) begin
      keep = $urandom_range(1, len - 1);
    end else if (kind == 17 && len > 1) begin
      pos = $urandom_range(1, len - 1);
      s[pos] = 8'($urandom);
    end else if (kind == 18 && len > 1) begin
      case (len)
        2: begin
          s[0] = 8'($urandom_range(8'hc0, 8'hc1));
        end
        3: begin
          if ($urandom_range(0, 1) == 0) begin
            s[0] = 8'he0;
            s[1] = 8'($urandom_range(8'h80, 8'h9f));
          end else begin
            s[0] = 8'hed;
            s[1] = 8'($urandom_range(8'ha0, 8'hbf));
          end
        end
        default: begin
          s[0] = 8'hf0;
          s[1] = 8'($urandom_range(8'h80, 8'h8f));
        end
      endcase
    end else if (kind == 19) begin
      keep = 1;
      s[0] = cont_byte();
    end
    for (int i = 0; i < keep; i++) text.push_back(s[i]);
  endtask

  // result side: random stall before each result
  initial begin : drain_side
    int hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QuietLimit) begin
      $display("%0t: no request moved for %0d cycles", $time, QuietLimit);
      $display("utf8_sanitizer_core_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int sent;
    int chars;
    sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, overlong and surrogate forms, stray continuations, bad leads
    idle_off = 1'b1;
    text = '{8'h00};
    send_text();
    text = '{8'h7f, 8'hc1, 8'hbf, 8'hdf, 8'hbf};
    send_text();
    idle_off = 1'b0;
    text = '{8'he0, 8'h80, 8'hed, 8'ha0, 8'hef, 8'hbf, 8'hbf};
    send_text();
    text = '{8'hf0, 8'h8f, 8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'hf8};
    send_text();
    // three held bytes broken at the end of string: every byte replaced
    idle_off = 1'b1;
    text = '{8'hf0, 8'h90, 8'h80, 8'hc2};
    send_text();
    idle_off = 1'b0;
    text = '{8'hff};
    send_text();
    wait_for_output();

    for (int k = 0; sent < 195; k++) begin
      idle_off = ($urandom_range(0, 4) == 0);
      chars = $urandom_range(1, 8);
      repeat (chars) add_char();
      sent += text.size();
      send_text();
      if (k == 12) wait_for_output();
    end

    wait_for_output();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && owed == 0) begin
      $display("utf8_sanitizer_core_tb OK");
    end else begin
      $display("utf8_sanitizer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
